// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on the rising edge, off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/bblur3_pkg.sv =====
package bblur3_pkg;

	localparam int CH_W          = 8;
	localparam int PIX_W         = 3 * CH_W;
	localparam int WIDTH_REG_W   = 11;
	localparam int HEIGHT_REG_W  = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_IDX_W     = 4;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int ROW_W         = 12;
	localparam int DIM_W         = 13;
	localparam int SUM_W         = 12;
	localparam int CNT_W         = 4;
	localparam int NUM_W         = 13;
	localparam int RECIP_W       = 20;
	localparam int RECIP_SHIFT   = 20;
	localparam int PROD_W        = NUM_W + RECIP_W;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 4'd0,
		CFG_FRAME_HEIGHT = 4'd1
	} cfg_reg_t;

	// red sits in the low byte, matching the stream data layout
	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	// where the output pixel lies in its frame: which neighbor rows/columns exist
	typedef struct packed {
		logic rv0;
		logic rv2;
		logic cv0;
		logic cv2;
		logic row_end;
		logic frame_end;
	} out_pos_t;

	// ceil(2^20 / (2*count)); exact floor division for numerators below 8192
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		case (count)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd6:    m = 20'd87382;
			4'd9:    m = 20'd58255;
			default: m = 20'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/box_blur_three_by_three_unit.sv =====
// 3x3 box blur on a raster RGB stream. One pixel or drain transfer is taken per clock;
// a result passes stages 1, 2 and 3 and the output register, and the output lags the
// input by one row plus one pixel, so width+1 drain transfers flush the end of a frame.
// Two line memories of MAX_WIDTH x 24 bits hold the two previous rows; each pixel does a
// read at accept and a write-back from stage 1 (the single read/write port pair per
// memory sets the one-pixel-per-clock rate), with a bypass when a one-pixel-wide frame
// hits the same entry on consecutive transfers. The mean is taken with a reciprocal
// multiply. Input stalls only while a finished result waits on the output register.
// Line memory contents are not cleared at reset. A write to the width or height register
// restarts the stream position and discards pending outputs; write it only while the
// block is idle. Writes to other indexes are ignored.
module box_blur_three_by_three_unit #(
	parameter int MAX_WIDTH = bblur3_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bblur3_pkg::PIX_W-1:0]       s_tdata,   // in_red, in_green, in_blue
	input  logic                               s_tuser,   // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bblur3_pkg::PIX_W-1:0]       m_tdata,   // out_red, out_green, out_blue
	output logic                               m_tuser,   // row_end
	output logic                               m_tlast,   // frame_end
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bblur3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bblur3_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bblur3_pkg::*;

	localparam int PTR_W  = $clog2(MAX_WIDTH);
	localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
	localparam int PEND_W = $clog2(MAX_WIDTH + 2);

	// configuration
	logic [WIDTH_REG_W-1:0]  frame_width_q;
	logic [HEIGHT_REG_W-1:0] frame_height_q;
	logic [DIM_W-1:0]        w_req, w_clamp, h_eff;
	logic [WEFF_W-1:0]       w_eff;
	logic                    cfg_fire, cfg_restart;

	// stream position
	logic [PTR_W-1:0]  ptr_q, ptr_next;
	logic [PTR_W-1:0]  ocol_q, ocol_next;
	logic [ROW_W-1:0]  orow_q, orow_next;
	logic [PEND_W-1:0] pending_q;
	logic              col_wrap, row_wrap;

	// accept stage
	logic     advance, accept, is_drain, act0, emit0, fwd_hit;
	rgb_t     px0;
	out_pos_t pos0;

	// line memories
	rgb_t upper_mem [MAX_WIDTH];
	rgb_t lower_mem [MAX_WIDTH];

	// stage 1: memory data back, window shift, write-back
	logic             valid_s1, emit_s1, fwd_s1;
	rgb_t             px_s1, up_rd_s1, lo_rd_s1, fwd_up_s1, fwd_lo_s1;
	rgb_t             upper_cur, lower_cur;
	logic [PTR_W-1:0] addr_s1;
	out_pos_t         pos_s1;

	rgb_t win_q [3][3];

	// stage 2: masked sums
	logic             valid_s2;
	out_pos_t         pos_s2;
	logic [2:0]       rv, cv;
	logic [1:0]       rows_n, cols_n;
	logic [CNT_W-1:0] count2;
	logic [SUM_W-1:0] sum_r2, sum_g2, sum_b2;

	// stage 3: reciprocal multiply
	logic              valid_s3, row_end_s3, frame_end_s3;
	logic [SUM_W-1:0]  sum_r_s3, sum_g_s3, sum_b_s3;
	logic [CNT_W-1:0]  count_s3;
	logic [RECIP_W-1:0] m3;
	logic [NUM_W-1:0]  num_r, num_g, num_b;
	logic [PROD_W-1:0] prod_r, prod_g, prod_b;
	rgb_t              mean3;

	// output register
	logic out_valid_q, out_row_end_q, out_frame_end_q;
	rgb_t out_pix_q;

	// ---------------------------------------------------------------- configuration
	assign cfg_ready   = 1'b1;
	assign cfg_fire    = cfg_valid & cfg_ready;
	// only a write to a defined register restarts the stream
	assign cfg_restart = cfg_fire
		&& (cfg_reg_t'(cfg_index) inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_fire) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_req = DIM_W'(frame_width_q);
		if (w_req == '0)
			w_clamp = DIM_W'(1);
		else if (w_req > DIM_W'(MAX_WIDTH))
			w_clamp = DIM_W'(MAX_WIDTH);
		else
			w_clamp = w_req;
		w_eff = WEFF_W'(w_clamp);
		if (frame_height_q == '0)
			h_eff = DIM_W'(1);
		else if (frame_height_q > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = frame_height_q;
	end

	// ---------------------------------------------------------------- accept stage
	assign advance  = !(valid_s3 && out_valid_q && !m_tready);
	assign s_tready = advance;
	assign accept   = s_tvalid & s_tready;
	assign is_drain = (opcode_t'(s_tuser) == OP_DRAIN);
	assign act0     = !is_drain || (pending_q != '0);
	assign emit0    = is_drain ? (pending_q != '0)
		: (pending_q == PEND_W'(w_eff) + PEND_W'(1));
	assign px0      = is_drain ? '0 : rgb_t'(s_tdata);

	assign ptr_next  = (WEFF_W'(ptr_q) + WEFF_W'(1) == w_eff) ? '0 : ptr_q + PTR_W'(1);
	assign col_wrap  = (WEFF_W'(ocol_q) + WEFF_W'(1) == w_eff);
	assign row_wrap  = (DIM_W'(orow_q) + DIM_W'(1) == h_eff);
	assign ocol_next = col_wrap ? '0 : ocol_q + PTR_W'(1);
	assign orow_next = !col_wrap ? orow_q : (row_wrap ? '0 : orow_q + ROW_W'(1));

	always_comb begin
		pos0.rv0       = (orow_q != '0);
		pos0.rv2       = !row_wrap;
		pos0.cv0       = (ocol_q != '0);
		pos0.cv2       = !col_wrap;
		pos0.row_end   = col_wrap;
		pos0.frame_end = col_wrap && row_wrap;
	end

	// the entry stage 1 writes this cycle is the one being read
	assign fwd_hit = valid_s1 && (addr_s1 == ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			pending_q <= '0;
		end else if (cfg_restart) begin
			ptr_q     <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			pending_q <= '0;
		end else if (accept && act0) begin
			ptr_q <= ptr_next;
			if (emit0) begin
				ocol_q <= ocol_next;
				orow_q <= orow_next;
			end
			if (!is_drain && !emit0)
				pending_q <= pending_q + PEND_W'(1);
			else if (is_drain)
				pending_q <= pending_q - PEND_W'(1);
		end
	end

	// ---------------------------------------------------------------- line memories
	always_ff @(posedge clk) begin
		if (accept && act0) begin
			up_rd_s1 <= upper_mem[ptr_q];
			lo_rd_s1 <= lower_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			upper_mem[addr_s1] <= lower_cur;
			lower_mem[addr_s1] <= px_s1;
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && act0;
			emit_s1  <= accept && emit0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			px_s1     <= px0;
			addr_s1   <= ptr_q;
			pos_s1    <= pos0;
			fwd_s1    <= fwd_hit;
			fwd_up_s1 <= lower_cur;
			fwd_lo_s1 <= px_s1;
		end
	end

	assign upper_cur = fwd_s1 ? fwd_up_s1 : up_rd_s1;
	assign lower_cur = fwd_s1 ? fwd_lo_s1 : lo_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win_q[i][j] <= '0;
		end else if (advance && valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= upper_cur;
			win_q[1][2] <= lower_cur;
			win_q[2][2] <= px_s1;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			pos_s2 <= pos_s1;
	end

	always_comb begin
		rv     = {pos_s2.rv2, 1'b1, pos_s2.rv0};
		cv     = {pos_s2.cv2, 1'b1, pos_s2.cv0};
		rows_n = 2'd1 + 2'(pos_s2.rv0) + 2'(pos_s2.rv2);
		cols_n = 2'd1 + 2'(pos_s2.cv0) + 2'(pos_s2.cv2);
		count2 = CNT_W'(rows_n) * CNT_W'(cols_n);
		sum_r2 = '0;
		sum_g2 = '0;
		sum_b2 = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (rv[i] && cv[j]) begin
					sum_r2 = sum_r2 + SUM_W'(win_q[i][j].red);
					sum_g2 = sum_g2 + SUM_W'(win_q[i][j].green);
					sum_b2 = sum_b2 + SUM_W'(win_q[i][j].blue);
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (advance)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_r_s3     <= sum_r2;
			sum_g_s3     <= sum_g2;
			sum_b_s3     <= sum_b2;
			count_s3     <= count2;
			row_end_s3   <= pos_s2.row_end;
			frame_end_s3 <= pos_s2.frame_end;
		end
	end

	// round half up: floor((2*sum + count) / (2*count))
	always_comb begin
		m3         = recip(count_s3);
		num_r      = {sum_r_s3, 1'b0} + NUM_W'(count_s3);
		num_g      = {sum_g_s3, 1'b0} + NUM_W'(count_s3);
		num_b      = {sum_b_s3, 1'b0} + NUM_W'(count_s3);
		prod_r     = PROD_W'(num_r) * PROD_W'(m3);
		prod_g     = PROD_W'(num_g) * PROD_W'(m3);
		prod_b     = PROD_W'(num_b) * PROD_W'(m3);
		mean3.red   = prod_r[RECIP_SHIFT +: CH_W];
		mean3.green = prod_g[RECIP_SHIFT +: CH_W];
		mean3.blue  = prod_b[RECIP_SHIFT +: CH_W];
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && valid_s3)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s3) begin
			out_pix_q       <= mean3;
			out_row_end_q   <= row_end_s3;
			out_frame_end_q <= frame_end_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = out_row_end_q;
	assign m_tlast  = out_frame_end_q;

endmodule

// ===== hdl/bblur3_checker.sv =====
`include "assert_macros.svh"

module bblur3_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [bblur3_pkg::PIX_W-1:0] m_tdata,
	input logic                         m_tuser,
	input logic                         m_tlast
);

	// a stalled result stays offered and unchanged
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// the last pixel of a frame is also the last of its row
	`ASSERT_IMPL(a_frame_end_row, clk, arst_n, m_tvalid && m_tlast, m_tuser)
	// input backpressure only comes from a blocked output
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind box_blur_three_by_three_unit bblur3_checker u_bblur3_checker (.*);

// ===== sim/tb_box_blur_three_by_three_unit.sv =====
`timescale 1ns / 1ps

module tb_box_blur_three_by_three_unit;
	import bblur3_pkg::*;

	localparam int MAX_W          = MAX_WIDTH_DEF;
	localparam int QUIET_CYCLES   = 12;
	localparam int RANDOM_PIXELS  = 180;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;

	typedef struct packed {
		rgb_t pixel;
		logic row_end;
		logic frame_end;
	} blur_result_t;

	class blur_scoreboard;
		rgb_t                    upper_row [MAX_W];
		rgb_t                    lower_row [MAX_W];
		rgb_t                    win [3][3];
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		int unsigned             col;
		int unsigned             row;
		int unsigned             pending;
		int unsigned             store_ptr;
		blur_result_t            expected_pixels [$];
		int unsigned             errors;

		function new();
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				lower_row[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			errors     = 0;
			restart();
		endfunction

		function void restart();
			col       = 0;
			row       = 0;
			pending   = 0;
			store_ptr = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_FRAME_WIDTH) begin
				width_reg = data[WIDTH_REG_W-1:0];
				restart();
			end else if (idx == CFG_FRAME_HEIGHT) begin
				height_reg = data[HEIGHT_REG_W-1:0];
				restart();
			end
		endfunction

		function void shift_pixel(rgb_t px, int unsigned w);
			int unsigned p;
			p = (store_ptr < w) ? store_ptr : 0;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = upper_row[p];
			win[1][2] = lower_row[p];
			win[2][2] = px;
			upper_row[p] = lower_row[p];
			lower_row[p] = px;
			p++;
			store_ptr = (p >= w) ? 0 : p;
		endfunction

		// mean of the in-frame neighbors of the oldest pending pixel
		function void push_blur(int unsigned w, int unsigned h);
			int unsigned  total, pos, idx, ro, co, cnt;
			int unsigned  sum_r, sum_g, sum_b;
			bit           rv [3];
			bit           cv [3];
			blur_result_t res;
			total = w * h;
			pos   = (row * w + col) % total;
			idx   = (pos + total - (pending % total)) % total;
			ro    = idx / w;
			co    = idx % w;
			rv[0] = ro > 0;
			rv[1] = 1'b1;
			rv[2] = ro + 1 < h;
			cv[0] = co > 0;
			cv[1] = 1'b1;
			cv[2] = co + 1 < w;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			cnt   = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if (rv[i] && cv[j]) begin
						sum_r += win[i][j].red;
						sum_g += win[i][j].green;
						sum_b += win[i][j].blue;
						cnt++;
					end
			res.pixel.red   = 8'((2 * sum_r + cnt) / (2 * cnt));
			res.pixel.green = 8'((2 * sum_g + cnt) / (2 * cnt));
			res.pixel.blue  = 8'((2 * sum_b + cnt) / (2 * cnt));
			res.row_end     = (co + 1 == w);
			res.frame_end   = (co + 1 == w) && (ro + 1 == h);
			expected_pixels.push_back(res);
		endfunction

		function void take_transfer(opcode_t op, rgb_t px);
			int unsigned w, h;
			w = eff_width();
			h = eff_height();
			if (col >= w) col = 0;
			if (row >= h) row = 0;
			if (op == OP_DRAIN) begin
				if (pending == 0) return;
				shift_pixel('0, w);
				push_blur(w, h);
				pending--;
				return;
			end
			shift_pixel(px, w);
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
			pending++;
			if (pending > w + 1) begin
				push_blur(w, h);
				pending--;
			end
		endfunction

		function void check_output(rgb_t px, logic re, logic fe);
			blur_result_t exp_res;
			if (expected_pixels.size() == 0) begin
				$error("output transfer with no pixel expected");
				errors++;
				return;
			end
			exp_res = expected_pixels.pop_front();
			if (px.red !== exp_res.pixel.red) begin
				$error("out_red: expected %0d, got %0d", exp_res.pixel.red, px.red);
				errors++;
			end
			if (px.green !== exp_res.pixel.green) begin
				$error("out_green: expected %0d, got %0d", exp_res.pixel.green, px.green);
				errors++;
			end
			if (px.blue !== exp_res.pixel.blue) begin
				$error("out_blue: expected %0d, got %0d", exp_res.pixel.blue, px.blue);
				errors++;
			end
			if (re !== exp_res.row_end) begin
				$error("row_end: expected %0b, got %0b", exp_res.row_end, re);
				errors++;
			end
			if (fe !== exp_res.frame_end) begin
				$error("frame_end: expected %0b, got %0b", exp_res.frame_end, fe);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;   // in_red, in_green, in_blue
	logic                  s_tuser   = 1'b0; // opcode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [PIX_W-1:0]      m_tdata;          // out_red, out_green, out_blue
	logic                  m_tuser;          // row_end
	logic                  m_tlast;          // frame_end
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int unsigned    src_idle_pct   = 0;
	int unsigned    sink_stall_pct = 0;
	int unsigned    random_pixels  = 0;
	int unsigned    phase_count    = 0;
	blur_scoreboard sb = new;

	box_blur_three_by_three_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_output(m_tdata, m_tuser, m_tlast);
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [CH_W-1:0] rand_channel();
		int unsigned r;
		r = $urandom_range(15);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return CH_W'($urandom_range(255));
	endfunction

	function automatic rgb_t rand_pixel();
		rgb_t px;
		px.red   = rand_channel();
		px.green = rand_channel();
		px.blue  = rand_channel();
		return px;
	endfunction

	// valid stays high across back-to-back transfers; only idling lowers it
	task automatic send_item(input opcode_t op, input rgb_t px);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_transfer(op, px);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle_mode(input int unsigned mode);
		case (mode % 4)
			0: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct   = 59;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct   = 0;
				sink_stall_pct = 59;
			end
			default: begin
				src_idle_pct   = 17;
				sink_stall_pct = 17;
			end
		endcase
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		wait_quiet();
		write_cfg(CFG_FRAME_WIDTH, w);
		write_cfg(CFG_FRAME_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	task automatic stream_pixels(input int unsigned n, input int unsigned noise_pct);
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(99) < noise_pct)
				send_item(OP_DRAIN, rand_pixel());
			send_item(OP_PIXEL, rand_pixel());
		end
	endtask

	task automatic drain_all(input int unsigned extra);
		int unsigned n;
		n = sb.eff_width() + 1 + extra;
		for (int unsigned k = 0; k < n; k++)
			send_item(OP_DRAIN, rand_pixel());
	endtask

	task automatic random_phase();
		int unsigned sel, w, h, eff_w, eff_h, n;
		logic [CFG_DATA_W-1:0] wdata;
		sel = $urandom_range(9);
		if (sel < 7)
			w = $urandom_range(8, 1);
		else if (sel < 9)
			w = $urandom_range(40, 9);
		else
			w = $urandom_range(2);
		sel = $urandom_range(11);
		if (sel < 9)
			h = $urandom_range(6, 1);
		else if (sel == 9)
			h = 0;
		else if (sel == 10)
			h = MAX_HEIGHT;
		else
			h = $urandom_range(8191, MAX_HEIGHT + 1);
		eff_w = (w == 0) ? 1 : w;
		eff_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
		if (eff_h <= 6) begin
			n = eff_w * eff_h * $urandom_range(3, 1);
			if ($urandom_range(3) == 0) n += $urandom_range(eff_w);
		end else begin
			n = eff_w * $urandom_range(5, 2);
		end
		if (n > 240) n = 240;
		// upper data bits lie above the width register and are dropped
		wdata = {2'($urandom_range(3)), 11'(w)};
		set_idle_mode(phase_count);
		phase_count++;
		configure(wdata, CFG_DATA_W'(h));
		stream_pixels(n, 3);
		random_pixels += n;
		drain_all($urandom_range(2));
	endtask

	initial begin
		rgb_t px;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame: corner, edge and interior means
		set_idle_mode(0);
		configure(3, 3);
		for (int k = 0; k < 9; k++) begin
			px.red   = (k % 2) ? 8'h00 : 8'hff;
			px.green = 8'(k * 31);
			px.blue  = 8'(8'hff - k * 17);
			send_item(OP_PIXEL, px);
		end
		drain_all(1);

		// single pixel frame; an unmapped register write must not restart the stream
		configure(1, 1);
		send_item(OP_PIXEL, 24'hffffff);
		send_item(OP_PIXEL, 24'h030201);
		wait_quiet();
		write_cfg(CFG_UNUSED_IDX, '1);
		cfg_valid <= 1'b0;
		drain_all(0);

		// zero width and height clamp to one
		configure(0, 0);
		send_item(OP_PIXEL, 24'h00ff00);
		drain_all(0);

		while (random_pixels < RANDOM_PIXELS)
			random_phase();

		// widest line, tallest frame: both writes clamp; the first outputs of the
		// frame come out once a full line plus one pixel is held
		set_idle_mode(3);
		configure(13'h07ff, 13'h1fff);
		stream_pixels(MAX_W + 8, 0);

		wait_quiet();
		if (sb.errors == 0 && sb.expected_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bblur3_pkg.sv
hdl/box_blur_three_by_three_unit.sv
hdl/bblur3_checker.sv
sim/tb_box_blur_three_by_three_unit.sv
